// File: sv/mf3i_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mf3i_pkg
// Shared widths, reset values and sort helpers for the interleaved 3x3
// median filter.
// ----------------------------------------------------------------------------
package mf3i_pkg;

    localparam int PIXEL_W         = 8;
    localparam int ROW_BYTES_W     = 11;
    localparam int ROW_BYTES_MIN   = 9;
    localparam int ROW_BYTES_RESET = 492;

    typedef logic [PIXEL_W-1:0] pixel_t;

    // One window column, its three rows kept in ascending order
    typedef struct packed {
        pixel_t lo;
        pixel_t mid;
        pixel_t hi;
    } triple_t;

    function automatic pixel_t min2(input pixel_t a, input pixel_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic pixel_t max2(input pixel_t a, input pixel_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic pixel_t med3(input pixel_t a, input pixel_t b, input pixel_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic triple_t sort3(input pixel_t a, input pixel_t b, input pixel_t c);
        triple_t t;
        t.lo  = min2(min2(a, b), c);
        t.hi  = max2(max2(a, b), c);
        t.mid = med3(a, b, c);
        return t;
    endfunction

    // Median of nine from three column-sorted triples
    function automatic pixel_t median9(input triple_t x, input triple_t y, input triple_t z);
        pixel_t lo_max;
        pixel_t mid_med;
        pixel_t hi_min;
        lo_max  = max2(max2(x.lo, y.lo), z.lo);
        mid_med = med3(x.mid, y.mid, z.mid);
        hi_min  = min2(min2(x.hi, y.hi), z.hi);
        return med3(lo_max, mid_med, hi_min);
    endfunction

endpackage
`default_nettype wire

// File: sv/median3x3_interleaved_filter_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// median3x3_interleaved_filter_core
// 3x3 median filter over an interleaved multi-channel 8-bit image stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one image byte per transfer in
//   raster order; frame_start marks the first byte of a frame and resets the
//   row and column position. Row length in bytes is set through cfg_wr_en /
//   cfg_wr_data (clamped to 9..MAX_ROW_BYTES) while the block is idle.
//   Output channel (out_valid/out_ready) carries one median per byte at row
//   >= 2 and byte column >= 2*CHANNEL_STRIDE; border bytes give no transfer.
//   Throughput: one byte per cycle while the receiver keeps up. A byte's
//   transfer loads the line-store read stage, then the result register;
//   the median network sits between those two registers.
//   The line store is one MAX_ROW_BYTES-deep memory holding two rows per
//   entry, with one read and one write per cycle; a read that hits the entry
//   being written in the same cycle takes the new data through a bypass.
//   When the receiver stalls, the result register holds its value and the
//   read stage takes border bytes until one owes a result; then in_ready drops.
//   Reset clears positions, the window and the valid flags and loads the
//   row length 492; the line store is not cleared (no clearing pass).
// ----------------------------------------------------------------------------
module median3x3_interleaved_filter_core #(
    parameter int MAX_ROW_BYTES  = 1024,
    parameter int CHANNEL_STRIDE = 3
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // configuration
    input  wire logic                              cfg_wr_en,
    input  wire logic [mf3i_pkg::ROW_BYTES_W-1:0]  cfg_wr_data,
    // input stream
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [mf3i_pkg::PIXEL_W-1:0]      pixel_byte,
    input  wire logic                              frame_start,
    // result stream
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [mf3i_pkg::PIXEL_W-1:0]           median_byte
);

    import mf3i_pkg::*;

    localparam int COL_W = $clog2(MAX_ROW_BYTES);
    localparam int CMP_W = (ROW_BYTES_W > COL_W + 1) ? ROW_BYTES_W : COL_W + 1;
    localparam int WIN_W = 3 * CHANNEL_STRIDE;
    localparam int ENT_W = 2 * PIXEL_W;

    // configuration
    logic [ROW_BYTES_W-1:0] row_bytes_reg;

    // position
    logic [COL_W-1:0] col_reg, col_next, cur_col;
    logic [1:0]       row_reg, row_next, cur_row;
    logic [CMP_W-1:0] row_len, row_ext, col_inc;

    // line store: entry = {upper row byte, lower row byte}
    logic [ENT_W-1:0] line_mem [MAX_ROW_BYTES];
    logic [ENT_W-1:0] rd_data_reg;

    // read stage
    logic             s1_valid_reg;
    logic             s1_produce_reg;
    logic [COL_W-1:0] s1_col_reg;
    pixel_t           s1_pixel_reg;
    logic             fwd_hit_reg, fwd_hit_next;
    logic [ENT_W-1:0] fwd_data_reg, wr_data;

    // window of column-sorted triples, index 0 newest
    triple_t win_reg [WIN_W];
    triple_t new_col;

    // result
    logic   out_valid_reg;
    pixel_t median_byte_reg, median_next;

    logic   in_fire, s1_move, produce_next;
    pixel_t up_byte, lo_byte;

    // ------------------------------------------------------------------
    // Handshake: the read stage moves on unless it carries a result and
    // the result register is still occupied.
    // ------------------------------------------------------------------
    assign s1_move  = s1_valid_reg && (!s1_produce_reg || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_move;
    assign in_fire  = in_valid && in_ready;

    // ------------------------------------------------------------------
    // Position tracking; frame start resets before the byte is placed.
    // ------------------------------------------------------------------
    always_comb
    begin
        cur_col = frame_start ? '0 : col_reg;
        cur_row = frame_start ? 2'd0 : row_reg;

        row_ext = CMP_W'(row_bytes_reg);
        if (row_ext < CMP_W'(ROW_BYTES_MIN))
            row_len = CMP_W'(ROW_BYTES_MIN);
        else if (row_ext > CMP_W'(MAX_ROW_BYTES))
            row_len = CMP_W'(MAX_ROW_BYTES);
        else
            row_len = row_ext;

        col_inc = CMP_W'(cur_col) + CMP_W'(1);
        if (col_inc >= row_len)
        begin
            col_next = '0;
            row_next = (cur_row < 2'd2) ? cur_row + 2'd1 : cur_row;
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
            row_next = cur_row;
        end

        produce_next = (cur_row == 2'd2) && (cur_col >= COL_W'(2 * CHANNEL_STRIDE));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_bytes_reg <= ROW_BYTES_W'(ROW_BYTES_RESET);
            col_reg       <= '0;
            row_reg       <= 2'd0;
        end
        else
        begin
            if (cfg_wr_en)
                row_bytes_reg <= cfg_wr_data;
            if (in_fire)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Line store: read on input transfer, write back when the read stage
    // moves on. Bypass the entry written at the same edge.
    // ------------------------------------------------------------------
    assign up_byte      = fwd_hit_reg ? fwd_data_reg[ENT_W-1:PIXEL_W]
                                      : rd_data_reg[ENT_W-1:PIXEL_W];
    assign lo_byte      = fwd_hit_reg ? fwd_data_reg[PIXEL_W-1:0]
                                      : rd_data_reg[PIXEL_W-1:0];
    assign wr_data      = {lo_byte, s1_pixel_reg};
    assign fwd_hit_next = s1_move && (cur_col == s1_col_reg);

    always_ff @(posedge clk)
    begin
        if (s1_move)
            line_mem[s1_col_reg] <= wr_data;
        if (in_fire)
            rd_data_reg <= line_mem[cur_col];
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_pixel_reg   <= pixel_byte;
            s1_col_reg     <= cur_col;
            s1_produce_reg <= produce_next;
            fwd_data_reg   <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_hit_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
                fwd_hit_reg  <= fwd_hit_next;
            end
            else if (s1_move)
                s1_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Window: sort the new vertical triple on entry, shift by one byte.
    // Median uses columns 0, S and 2S of the shifted window.
    // ------------------------------------------------------------------
    assign new_col     = sort3(up_byte, lo_byte, s1_pixel_reg);
    assign median_next = median9(new_col, win_reg[CHANNEL_STRIDE-1],
                                 win_reg[2*CHANNEL_STRIDE-1]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < WIN_W; k++)
                win_reg[k] <= '0;
        end
        else if (s1_move)
        begin
            for (int k = WIN_W - 1; k > 0; k--)
                win_reg[k] <= win_reg[k-1];
            win_reg[0] <= new_col;
        end
    end

    // ------------------------------------------------------------------
    // Result register: load on a producing move, drop on transfer.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_move && s1_produce_reg)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move && s1_produce_reg)
            median_byte_reg <= median_next;
    end

    assign out_valid   = out_valid_reg;
    assign median_byte = median_byte_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_produce_reg) |-> (!out_valid_reg || out_ready))
        else $error("pending result overwritten");

    a_empty_stage_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_valid_reg |-> in_ready)
        else $error("empty read stage refuses input");

    a_bypass_needs_move: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && fwd_hit_next) |-> s1_move)
        else $error("bypass without a write");

    a_frame_start_col: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && frame_start) |=> (s1_col_reg == '0) && !s1_produce_reg)
        else $error("frame start did not reset position");

endmodule
`default_nettype wire

// File: dv/median3x3_interleaved_filter_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median3x3_interleaved_filter_checker
// Watches the configuration port and both streams of the interleaved 3x3
// median filter. Keeps its own line stores, window and positions, queues the
// median due for every accepted byte that owes one, and compares each result
// transfer with the oldest queued median.
// ----------------------------------------------------------------------------
module median3x3_interleaved_filter_checker #(
    parameter int MAX_ROW_BYTES  = 1024,
    parameter int CHANNEL_STRIDE = 3
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [mf3i_pkg::ROW_BYTES_W-1:0] cfg_wr_data,
    input  wire logic                             in_valid,
    input  wire logic                             in_ready,
    input  wire logic [mf3i_pkg::PIXEL_W-1:0]     pixel_byte,
    input  wire logic                             frame_start,
    input  wire logic                             out_valid,
    input  wire logic                             out_ready,
    input  wire logic [mf3i_pkg::PIXEL_W-1:0]     median_byte,
    output int                                    fail_count,
    output int                                    expected_left
);

    import mf3i_pkg::*;

    localparam int WIN_W       = 3 * CHANNEL_STRIDE;
    localparam int PRINT_LIMIT = 100;

    pixel_t                 older_row [MAX_ROW_BYTES];
    pixel_t                 newer_row [MAX_ROW_BYTES];
    pixel_t                 win [3][WIN_W];
    int unsigned            col_pos;
    int unsigned            row_pos;
    logic [ROW_BYTES_W-1:0] row_len;
    pixel_t                 median_q [$];

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_LIMIT)
            $display("ERROR @%0t: %s", $time, msg);
        fail_count++;
    endtask

    // Fifth smallest of nine: the value with at most four below it and at
    // least five at or below it
    function automatic pixel_t median_of_nine(input logic [8:0][PIXEL_W-1:0] v);
        int     below;
        int     not_above;
        int     i;
        int     j;
        pixel_t pick;
        pick = v[0];
        for (i = 0; i < 9; i++)
        begin
            below     = 0;
            not_above = 0;
            for (j = 0; j < 9; j++)
            begin
                if (v[j] < v[i])
                    below++;
                if (v[j] <= v[i])
                    not_above++;
            end
            if (below <= 4 && not_above >= 5)
                pick = v[i];
        end
        return pick;
    endfunction

    task automatic predict_byte(input pixel_t px, input logic fs);
        int unsigned                 len;
        int unsigned                 c;
        pixel_t                      up;
        pixel_t                      lo;
        logic [8:0][PIXEL_W-1:0]     nine;
        int                          n;
        len = row_len;
        if (len < ROW_BYTES_MIN)
            len = ROW_BYTES_MIN;
        if (len > MAX_ROW_BYTES)
            len = MAX_ROW_BYTES;
        if (fs)
        begin
            col_pos = 0;
            row_pos = 0;
        end
        c  = col_pos;
        up = '0;
        lo = '0;
        if (c < MAX_ROW_BYTES)
        begin
            up           = older_row[c];
            lo           = newer_row[c];
            older_row[c] = lo;
            newer_row[c] = px;
        end
        // shift the window; column 0 is the newest
        for (int r = 0; r < 3; r++)
            for (int k = WIN_W - 1; k > 0; k--)
                win[r][k] = win[r][k-1];
        win[0][0] = up;
        win[1][0] = lo;
        win[2][0] = px;
        if (row_pos >= 2 && c >= 2 * CHANNEL_STRIDE)
        begin
            n = 0;
            for (int r = 0; r < 3; r++)
                for (int k = 0; k < 3; k++)
                begin
                    nine[n] = win[r][k*CHANNEL_STRIDE];
                    n++;
                end
            median_q.insert(median_q.size(), median_of_nine(nine));
        end
        if (c + 1 >= len)
        begin
            col_pos = 0;
            if (row_pos < 2)
                row_pos++;
        end
        else
            col_pos = c + 1;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ROW_BYTES; i++)
            begin
                older_row[i] = '0;
                newer_row[i] = '0;
            end
            for (int r = 0; r < 3; r++)
                for (int k = 0; k < WIN_W; k++)
                    win[r][k] = '0;
            col_pos    = 0;
            row_pos    = 0;
            row_len    = ROW_BYTES_W'(ROW_BYTES_RESET);
            fail_count = 0;
            median_q.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (median_q.size() == 0)
                    report_mismatch($sformatf("median_byte %0d with no median due",
                                              median_byte));
                else
                begin
                    want = median_q.pop_front();
                    if (median_byte !== want)
                        report_mismatch($sformatf("median_byte %0d, want %0d",
                                                  median_byte, want));
                end
            end
            if (in_valid && in_ready)
                predict_byte(pixel_byte, frame_start);
            if (cfg_wr_en)
                row_len = cfg_wr_data;
        end
        expected_left = median_q.size();
    end

endmodule

// File: dv/median3x3_interleaved_filter_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median3x3_interleaved_filter_core_tb
// Streams interleaved image bytes through the 3x3 median filter over a range
// of row lengths, clamped ones included, with random idle bursts on both
// streams, a long result stall and a row shrink in the middle of a frame. A
// checker beside the block predicts and compares every median.
// ----------------------------------------------------------------------------
module median3x3_interleaved_filter_core_tb;

    import mf3i_pkg::*;

    localparam int MAX_ROW_BYTES    = 1024;
    localparam int CHANNEL_STRIDE   = 3;
    // a result passes the read stage and the result register; leave some margin
    localparam int SETTLE_CYCLES    = 8;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int RANDOM_BYTES     = 400;
    localparam int CYCLE_LIMIT      = 1000000;

    // pixel value flavors per frame
    typedef enum int {PIX_FULL, PIX_TIES, PIX_EXTREMES} pixel_mode_t;

    logic                   clk         = 1'b0;
    logic                   rst_n       = 1'b0;
    logic                   cfg_wr_en   = 1'b0;
    logic [ROW_BYTES_W-1:0] cfg_wr_data = '0;
    logic                   in_valid    = 1'b0;
    logic                   in_ready;
    pixel_t                 pixel_byte  = '0;
    logic                   frame_start = 1'b0;
    logic                   out_valid;
    logic                   out_ready   = 1'b0;
    pixel_t                 median_byte;

    int fail_count;
    int expected_left;
    int cycle_count   = 0;
    bit idling_on     = 1'b1;
    bit sink_hold_req = 1'b0;
    int row_setting   = ROW_BYTES_RESET;

    median3x3_interleaved_filter_core #(
        .MAX_ROW_BYTES  (MAX_ROW_BYTES),
        .CHANNEL_STRIDE (CHANNEL_STRIDE)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .pixel_byte  (pixel_byte),
        .frame_start (frame_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .median_byte (median_byte)
    );

    median3x3_interleaved_filter_checker #(
        .MAX_ROW_BYTES  (MAX_ROW_BYTES),
        .CHANNEL_STRIDE (CHANNEL_STRIDE)
    ) i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pixel_byte    (pixel_byte),
        .frame_start   (frame_start),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .median_byte   (median_byte),
        .fail_count    (fail_count),
        .expected_left (expected_left)
    );

    always #2 clk = ~clk;

    // Watchdog: end the run if the streams lock up
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side. Hold off for a long stretch when asked, otherwise stall in
    // random bursts while idling is on, and accept every cycle when it is off.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge clk);
                out_ready <= 1'b1;
            end
            else if (idling_on && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Row length as the block applies it, for sizing frames only
    function automatic int clamp_row(input int v);
        if (v < ROW_BYTES_MIN)
            return ROW_BYTES_MIN;
        if (v > MAX_ROW_BYTES)
            return MAX_ROW_BYTES;
        return v;
    endfunction

    function automatic pixel_t pick_pixel(input pixel_mode_t mode);
        case (mode)
            PIX_TIES:     return pixel_t'($urandom_range(100, 103));
            PIX_EXTREMES: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:      return pixel_t'($urandom_range(0, 255));
        endcase
    endfunction

    // Offer one byte and hold it until the block takes the transfer. An idle
    // burst may come first; valid drops and rises on different falling edges.
    task automatic push_byte(input pixel_t b, input logic fs);
        int gap;
        if (idling_on && $urandom_range(0, 9) == 0)
        begin
            gap = $urandom_range(1, 14);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        pixel_byte  <= b;
        frame_start <= fs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // Send n bytes; the first one opens a frame unless the stream continues
    // the current one. A noisy frame restarts itself at a random byte.
    task automatic send_frame(input int n, input bit opens, input bit noisy,
                              input pixel_mode_t mode);
        int restart_at;
        restart_at = (noisy && n > 1) ? $urandom_range(1, n - 1) : -1;
        for (int i = 0; i < n; i++)
            push_byte(pick_pixel(mode), (opens && i == 0) || i == restart_at);
    endtask

    // Drop valid and wait for the block to go quiet: every due median out,
    // then a SETTLE_CYCLES wait for bytes still in the read stage
    task automatic drain_results();
        @(negedge clk);
        in_valid    <= 1'b0;
        frame_start <= 1'b0;
        wait (expected_left == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_row_len(input int v);
        drain_results();
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= ROW_BYTES_W'(v);
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        row_setting = v;
    endtask

    initial
    begin
        int          sent;
        int          len;
        int          n;
        int          pick;
        pixel_mode_t mode;
        pixel_t      v;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: a zero row length clamps up to nine; three rows, the first two
        // with pixel extremes; the first medians follow the border columns
        write_row_len(0);
        for (int i = 0; i < 27; i++)
        begin
            if (i < 9)
                v = (i % 2) ? 8'hFF : 8'h00;
            else if (i < 18)
                v = (i % 3) ? 8'h00 : 8'hFF;
            else
                v = pixel_t'((i * 53) & 8'hFF);
            push_byte(v, i == 0);
        end

        // All-ones length clamps down to the largest row: one full row must
        // wrap into row one, then shorter rows continue the frame and give
        // medians only if that wrap happened
        write_row_len(2047);
        send_frame(MAX_ROW_BYTES, 1'b1, 1'b0, PIX_FULL);
        write_row_len(ROW_BYTES_MIN);
        send_frame(ROW_BYTES_MIN * 3, 1'b0, 1'b0, PIX_FULL);

        // Largest length written exactly; a short frame only
        write_row_len(MAX_ROW_BYTES);
        send_frame(200, 1'b1, 1'b0, PIX_TIES);

        // Shrink the row in mid-frame: the column is past the new length, so
        // the block processes it as is and then wraps
        write_row_len(30);
        send_frame(30 * 4 + 25, 1'b1, 1'b0, PIX_FULL);
        write_row_len(17);
        send_frame(17 * 3 + 5, 1'b0, 1'b0, PIX_FULL);

        // Smallest legal length, then a long result stall while bytes keep
        // coming so the block backs up into the input
        write_row_len(ROW_BYTES_MIN);
        send_frame(ROW_BYTES_MIN * 4, 1'b1, 1'b1, PIX_EXTREMES);
        write_row_len(12);
        sink_hold_req = 1'b1;
        send_frame(12 * 10, 1'b1, 1'b0, PIX_FULL);

        // Random frames: mostly short rows, a few long or clamped ones
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 19);
            if (pick < 3)
                write_row_len($urandom_range(0, ROW_BYTES_MIN - 1));
            else if (pick < 5)
                write_row_len($urandom_range(49, 160));
            else if (pick == 5)
                write_row_len($urandom_range(MAX_ROW_BYTES + 1, 2047));
            else if (pick < 16)
                write_row_len($urandom_range(ROW_BYTES_MIN, 48));
            else if (pick < 18)
                drain_results();
            idling_on = ($urandom_range(0, 4) != 0);
            len = clamp_row(row_setting);
            case ($urandom_range(0, 9))
                0:       mode = PIX_TIES;
                1:       mode = PIX_EXTREMES;
                default: mode = PIX_FULL;
            endcase
            if (len > 200 || $urandom_range(0, 9) == 0)
                n = $urandom_range(1, (len > 100) ? 200 : 2 * len);
            else
                n = $urandom_range(3, 5) * len + $urandom_range(0, len - 1);
            send_frame(n, 1'b1, $urandom_range(0, 9) == 0, mode);
            sent += n;
        end

        // Last stretch with no idling on either side
        idling_on = 1'b0;
        write_row_len(ROW_BYTES_MIN);
        send_frame(ROW_BYTES_MIN * 4 + 3, 1'b1, 1'b0, PIX_FULL);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
